>>> hw/rtl/ngvs_pkg.sv
// ----------------------------------------------------------------------------
// ngvs_pkg
// Shared types and constants of the nearest grid value search block: widths,
// controller states, read and result selects, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ngvs_pkg;

  localparam int GRID_DEPTH_DEF = 256;
  localparam int DATA_W         = 32;
  localparam int IDX_W          = 8;
  localparam int CNT_W          = 9;

  // Item function codes.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_PROBE,
    ST_MID,
    ST_BELOW,
    ST_ABOVE
  } state_t;

  // Which grid index the memory reads in the current cycle.
  typedef enum logic [2:0] {
    RD_ZERO,
    RD_LAST,
    RD_MID,
    RD_BELOW,
    RD_ABOVE
  } rd_sel_t;

  // Which value is loaded into the result register.
  typedef enum logic [2:0] {
    RES_FIRST,
    RES_RDATA,
    RES_MID,
    RES_PICK_BELOW,
    RES_PICK_ABOVE
  } res_sel_t;

  typedef struct packed {
    logic     write;
    logic     capture;
    rd_sel_t  rd_sel;
    logic     save_first;
    logic     init_bounds;
    logic     set_mid;
    logic     save_mid;
    logic     hi_to_mid;
    logic     lo_to_mid1;
    logic     res_load;
    res_sel_t res_sel;
  } ngvs_cmd_t;

  typedef struct packed {
    logic t_le_first;
    logic t_ge_rd;
    logic t_lt_rd;
    logic t_gt_rd;
    logic rd_eq_t;
    logic mid_gt0;
    logic mid_up_ok;
    logic lo_lt_mid;
    logic mid1_lt_hi;
  } ngvs_status_t;

endpackage

>>> hw/rtl/ngvs_ctrl.sv
// ----------------------------------------------------------------------------
// ngvs_ctrl
// Controller state machine: sequences the bound checks and the binary search
// probes, and raises the result strobe.
// ----------------------------------------------------------------------------
module ngvs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  func,
  input  ngvs_pkg::ngvs_status_t status,
  output ngvs_pkg::ngvs_cmd_t   cmd,
  output logic                  busy,
  output logic                  done
);

  ngvs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ngvs_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.res_load;
    end
  end

  assign busy = (state != ngvs_pkg::ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.rd_sel  = ngvs_pkg::RD_ZERO;
    cmd.res_sel = ngvs_pkg::RES_RDATA;
    unique case (state)
      ngvs_pkg::ST_IDLE: begin
        if (start) begin
          if (func == ngvs_pkg::FUNC_QUERY) begin
            cmd.capture = 1'b1;
            cmd.rd_sel  = ngvs_pkg::RD_ZERO;
            state_next  = ngvs_pkg::ST_FIRST;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ngvs_pkg::ST_FIRST: begin
        cmd.save_first = 1'b1;
        cmd.rd_sel     = ngvs_pkg::RD_LAST;
        state_next     = ngvs_pkg::ST_LAST;
      end
      ngvs_pkg::ST_LAST: begin
        priority if (status.t_le_first) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = ngvs_pkg::RES_FIRST;
          state_next   = ngvs_pkg::ST_IDLE;
        end else if (status.t_ge_rd) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = ngvs_pkg::RES_RDATA;
          state_next   = ngvs_pkg::ST_IDLE;
        end else begin
          cmd.init_bounds = 1'b1;
          state_next      = ngvs_pkg::ST_PROBE;
        end
      end
      ngvs_pkg::ST_PROBE: begin
        cmd.set_mid = 1'b1;
        cmd.rd_sel  = ngvs_pkg::RD_MID;
        state_next  = ngvs_pkg::ST_MID;
      end
      ngvs_pkg::ST_MID: begin
        cmd.save_mid = 1'b1;
        priority if (status.rd_eq_t) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = ngvs_pkg::RES_RDATA;
          state_next   = ngvs_pkg::ST_IDLE;
        end else if (status.t_lt_rd) begin
          if (status.mid_gt0) begin
            cmd.rd_sel = ngvs_pkg::RD_BELOW;
            state_next = ngvs_pkg::ST_BELOW;
          end else begin
            cmd.hi_to_mid = 1'b1;
            if (status.lo_lt_mid) begin
              state_next = ngvs_pkg::ST_PROBE;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = ngvs_pkg::RES_RDATA;
              state_next   = ngvs_pkg::ST_IDLE;
            end
          end
        end else begin
          if (status.mid_up_ok) begin
            cmd.rd_sel = ngvs_pkg::RD_ABOVE;
            state_next = ngvs_pkg::ST_ABOVE;
          end else begin
            cmd.lo_to_mid1 = 1'b1;
            if (status.mid1_lt_hi) begin
              state_next = ngvs_pkg::ST_PROBE;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = ngvs_pkg::RES_RDATA;
              state_next   = ngvs_pkg::ST_IDLE;
            end
          end
        end
      end
      ngvs_pkg::ST_BELOW: begin
        if (status.t_gt_rd) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = ngvs_pkg::RES_PICK_BELOW;
          state_next   = ngvs_pkg::ST_IDLE;
        end else begin
          cmd.hi_to_mid = 1'b1;
          if (status.lo_lt_mid) begin
            state_next = ngvs_pkg::ST_PROBE;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = ngvs_pkg::RES_MID;
            state_next   = ngvs_pkg::ST_IDLE;
          end
        end
      end
      ngvs_pkg::ST_ABOVE: begin
        if (status.t_lt_rd) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = ngvs_pkg::RES_PICK_ABOVE;
          state_next   = ngvs_pkg::ST_IDLE;
        end else begin
          cmd.lo_to_mid1 = 1'b1;
          if (status.mid1_lt_hi) begin
            state_next = ngvs_pkg::ST_PROBE;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = ngvs_pkg::RES_MID;
            state_next   = ngvs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ngvs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/ngvs_dp.sv
// ----------------------------------------------------------------------------
// ngvs_dp
// Datapath: grid memory with registered read, count register, search bounds,
// comparators and the nearer-of-two selection feeding the result register.
// ----------------------------------------------------------------------------
module ngvs_dp #(
  parameter int GRID_DEPTH = ngvs_pkg::GRID_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ngvs_pkg::ngvs_cmd_t                 cmd,
  output ngvs_pkg::ngvs_status_t              status,
  input  logic                                cfg_we,
  input  logic [ngvs_pkg::CNT_W-1:0]          cfg_grid_count,
  input  logic [ngvs_pkg::IDX_W-1:0]          entry_index,
  input  logic signed [ngvs_pkg::DATA_W-1:0]  entry_value,
  input  logic signed [ngvs_pkg::DATA_W-1:0]  target,
  output logic signed [ngvs_pkg::DATA_W-1:0]  closest
);

  localparam int AW = $clog2(GRID_DEPTH);
  localparam int CW = ngvs_pkg::CNT_W;
  localparam int DW = ngvs_pkg::DATA_W;

  logic [DW-1:0] mem [GRID_DEPTH];

  logic [CW-1:0]        grid_count;
  logic [CW-1:0]        lo, hi, mid;
  logic signed [DW-1:0] t_reg, first_val, m_val, rdata;

  logic [CW-1:0]        n;
  logic [CW:0]          mid_sum, mid_up;
  logic [CW-1:0]        mid_new, rd_idx;
  logic signed [DW-1:0] pick_lo, pick_hi, pick_val, res;
  logic signed [DW:0]   d_lo, d_hi;

  // Effective count: zero acts as one, anything above the depth as the depth.
  always_comb begin
    n = grid_count;
    if (grid_count == '0) begin
      n = CW'(1);
    end else if (32'(grid_count) > GRID_DEPTH) begin
      n = CW'(GRID_DEPTH);
    end
  end

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid_new = mid_sum[CW:1];
  assign mid_up  = {1'b0, mid} + (CW+1)'(1);

  always_comb begin
    unique case (cmd.rd_sel)
      ngvs_pkg::RD_ZERO:  rd_idx = '0;
      ngvs_pkg::RD_LAST:  rd_idx = n - CW'(1);
      ngvs_pkg::RD_MID:   rd_idx = mid_new;
      ngvs_pkg::RD_BELOW: rd_idx = mid - CW'(1);
      ngvs_pkg::RD_ABOVE: rd_idx = mid_up[CW-1:0];
      default:            rd_idx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.write && (32'(entry_index) < GRID_DEPTH)) begin
      mem[AW'(entry_index)] <= entry_value;
    end
    rdata <= mem[AW'(rd_idx)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_count <= CW'(1);
    end else if (cfg_we) begin
      grid_count <= cfg_grid_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture)     t_reg     <= target;
    if (cmd.save_first)  first_val <= rdata;
    if (cmd.save_mid)    m_val     <= rdata;
    if (cmd.set_mid)     mid       <= mid_new;
    if (cmd.init_bounds) begin
      lo <= '0;
      hi <= n;
    end
    if (cmd.hi_to_mid)   hi <= mid;
    if (cmd.lo_to_mid1)  lo <= mid_up[CW-1:0];
    if (cmd.res_load)    closest <= res;
  end

  // Nearer of the two bracketing entries, a tie going to the upper one.
  assign pick_lo  = (cmd.res_sel == ngvs_pkg::RES_PICK_BELOW) ? rdata : m_val;
  assign pick_hi  = (cmd.res_sel == ngvs_pkg::RES_PICK_BELOW) ? m_val : rdata;
  assign d_lo     = {t_reg[DW-1], t_reg} - {pick_lo[DW-1], pick_lo};
  assign d_hi     = {pick_hi[DW-1], pick_hi} - {t_reg[DW-1], t_reg};
  assign pick_val = (d_lo >= d_hi) ? pick_hi : pick_lo;

  always_comb begin
    unique case (cmd.res_sel)
      ngvs_pkg::RES_FIRST:      res = first_val;
      ngvs_pkg::RES_RDATA:      res = rdata;
      ngvs_pkg::RES_MID:        res = m_val;
      ngvs_pkg::RES_PICK_BELOW: res = pick_val;
      ngvs_pkg::RES_PICK_ABOVE: res = pick_val;
      default:                  res = rdata;
    endcase
  end

  assign status.t_le_first = (t_reg <= first_val);
  assign status.t_ge_rd    = (t_reg >= rdata);
  assign status.t_lt_rd    = (t_reg < rdata);
  assign status.t_gt_rd    = (t_reg > rdata);
  assign status.rd_eq_t    = (t_reg == rdata);
  assign status.mid_gt0    = (mid != '0);
  assign status.mid_up_ok  = (mid_up < {1'b0, n});
  assign status.lo_lt_mid  = (lo < mid);
  assign status.mid1_lt_hi = (mid_up < {1'b0, hi});

endmodule

>>> hw/rtl/nearest_grid_value_search_top.sv
// ----------------------------------------------------------------------------
// nearest_grid_value_search_top
// Nearest grid value search: an ascending grid of signed Q16.16 values and a
// binary search that snaps a target to the nearest grid entry.
// ----------------------------------------------------------------------------
// Usage. A transaction on the command channel is taken at a rising edge where
// start is high and busy is low. With func at load, entry_value is written to
// grid entry entry_index in that same cycle, busy stays low and no result is
// produced, so loads may follow one another every cycle. With func at query,
// the target is captured and busy rises until the answer is delivered.
// The answer appears on closest, with done high for exactly one cycle; the
// receiver cannot hold it off. busy falls in that same cycle, so the next
// command may be started while done is high.
// A query whose target lies at or outside the grid ends is answered after one
// memory read each for the first and last entry; otherwise it goes on with P
// binary search probes, where P is at most about log2 of the count plus one.
// Each probe reads the middle entry and then, unless that entry equals the
// target or has no neighbor on the side of the target, one neighbor through
// the single read port of the grid memory, whose read data is registered.
// The count register is written through cfg_valid/cfg_ready/cfg_grid_count
// and is accepted whenever no query is in flight. Reset sets the count to one
// and the controller to idle; grid contents are not cleared and must be
// loaded before they are searched.
// ----------------------------------------------------------------------------
module nearest_grid_value_search_top #(
  parameter int GRID_DEPTH = ngvs_pkg::GRID_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func,
  input  logic [ngvs_pkg::IDX_W-1:0]          entry_index,
  input  logic signed [ngvs_pkg::DATA_W-1:0]  entry_value,
  input  logic signed [ngvs_pkg::DATA_W-1:0]  target,
  output logic                                done,
  output logic signed [ngvs_pkg::DATA_W-1:0]  closest,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ngvs_pkg::CNT_W-1:0]          cfg_grid_count
);

  ngvs_pkg::ngvs_cmd_t    cmd;
  ngvs_pkg::ngvs_status_t status;

  // The count may change only while no query is being searched.
  assign cfg_ready = ~busy;

  ngvs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  ngvs_dp #(
    .GRID_DEPTH (GRID_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_grid_count (cfg_grid_count),
    .entry_index    (entry_index),
    .entry_value    (entry_value),
    .target         (target),
    .closest        (closest)
  );

endmodule

>>> hw/rtl/ngvs_checker.sv
// ----------------------------------------------------------------------------
// ngvs_checker
// Port-level checks of the command/result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module ngvs_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic func,
  input logic done
);

  // A result only ever follows a cycle in which a query was in flight.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a query in flight");

  // The result is delivered as the block returns to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy still high while the result is shown");

  // An accepted query keeps the block busy in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func) |=> busy)
    else $error("accepted query did not raise busy");

  // A load produces no result and leaves the block idle.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !func) |=> (!busy && !done))
    else $error("load transaction produced a result or raised busy");

endmodule

bind nearest_grid_value_search_top ngvs_checker u_ngvs_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .func  (func),
  .done  (done)
);
